[hw/rtl/ptp_pkg.sv]
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants, register indexes and helpers for the point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_NUM       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 66;
  localparam int MAG_W         = 64;
  localparam int DIV_STEPS     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3_C01 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3_C23 = 3'd7;

  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } clamp_t;

  // clamp a sign/magnitude quotient to the signed 32-bit range
  function automatic clamp_t ptp_clamp(input logic neg, input logic ovf,
                                       input logic [COORD_W-1:0] q);
    clamp_t r;
    r.sat = 1'b0;
    r.val = q;
    if (!neg) begin
      if (ovf || q > POS_MAX) begin
        r.sat = 1'b1;
        r.val = POS_MAX;
      end
    end else begin
      if (ovf || q > NEG_MAX) begin
        r.sat = 1'b1;
        r.val = NEG_MAX;
      end else begin
        r.val = ~q + 32'd1;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/ptp_column.sv]
// ----------------------------------------------------------------------------
// ptp_column
// One matrix column: four products, exact sum, then sign and magnitude.
// Three register stages.
// ----------------------------------------------------------------------------
module ptp_column #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [ptp_pkg::COORD_W-1:0]   x,
  input  logic signed [ptp_pkg::COORD_W-1:0]   y,
  input  logic signed [ptp_pkg::COORD_W-1:0]   z,
  input  logic signed [ptp_pkg::COORD_W-1:0]   m0,
  input  logic signed [ptp_pkg::COORD_W-1:0]   m1,
  input  logic signed [ptp_pkg::COORD_W-1:0]   m2,
  input  logic signed [ptp_pkg::COORD_W-1:0]   m3,
  output logic                                 neg,
  output logic        [ptp_pkg::MAG_W-1:0]     mag
);
  import ptp_pkg::*;

  logic signed [PROD_W-1:0] p0, p1, p2, p3;
  logic signed [SUM_W-1:0]  sum;
  logic        [SUM_W-1:0]  sum_abs;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= m0 * x;
      p1 <= m1 * y;
      p2 <= m2 * z;
      p3 <= PROD_W'(m3) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(p3);
    end
  end

  assign sum_abs = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

  always_ff @(posedge clk) begin
    if (en) begin
      neg <= sum[SUM_W-1];
      mag <= sum_abs[MAG_W-1:0];
    end
  end

endmodule

[hw/rtl/ptp_div.sv]
// ----------------------------------------------------------------------------
// ptp_div
// Pipelined restoring divider: 64-bit magnitude by 32-bit divisor, one
// quotient bit per stage, overflow when the quotient needs more than 32 bits.
// ----------------------------------------------------------------------------
module ptp_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ptp_pkg::MAG_W-1:0]       dividend,
  input  logic [ptp_pkg::COORD_W-1:0]     divisor,
  input  logic                            neg,
  output logic [ptp_pkg::COORD_W-1:0]     quo,
  output logic                            ovf,
  output logic                            neg_out
);
  import ptp_pkg::*;

  logic [COORD_W-1:0] rem  [0:DIV_STEPS];
  logic [COORD_W-1:0] low  [0:DIV_STEPS];
  logic [COORD_W-1:0] dvs  [0:DIV_STEPS];
  logic [COORD_W-1:0] q    [0:DIV_STEPS];
  logic               sgn  [0:DIV_STEPS];
  logic               ov   [0:DIV_STEPS];

  // entry stage: the high half is the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= dividend[MAG_W-1:COORD_W] >= divisor;
      rem[0] <= dividend[MAG_W-1:COORD_W];
      low[0] <= dividend[COORD_W-1:0];
      dvs[0] <= divisor;
      q[0]   <= '0;
      sgn[0] <= neg;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [COORD_W:0] trial;
    logic             fit;
    assign trial = {rem[k], low[k][COORD_W-1]};
    assign fit   = trial >= {1'b0, dvs[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fit ? COORD_W'(trial - {1'b0, dvs[k]}) : trial[COORD_W-1:0];
        low[k+1] <= {low[k][COORD_W-2:0], 1'b0};
        q[k+1]   <= {q[k][COORD_W-2:0], fit};
        dvs[k+1] <= dvs[k];
        sgn[k+1] <= sgn[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  assign quo     = q[DIV_STEPS];
  assign ovf     = ov[DIV_STEPS];
  assign neg_out = sgn[DIV_STEPS];

endmodule

[hw/rtl/point_transform_perspective_core.sv]
// ----------------------------------------------------------------------------
// point_transform_perspective_core
// 4x4 homogeneous point transform with perspective divide, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one point (in_x, in_y, in_z).
//   Output channel out_valid/out_stall carries out_x/y/z, w_was_zero and
//   saturated. A request moves when valid is high and stall is low.
//   The matrix sits in eight 64-bit registers written through cfg_we,
//   cfg_index and cfg_data; write them only while the pipeline is empty.
// Throughput: one point per cycle unless a waiting result is stalled. The
//   depth is set by the 32-stage divider, one quotient bit per stage,
//   after three multiply/sum stages, one divisor select stage, the divider
//   entry stage and the output stage.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises.
// ----------------------------------------------------------------------------
module point_transform_perspective_core #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ptp_pkg::COORD_W-1:0]  in_x,
  input  logic signed [ptp_pkg::COORD_W-1:0]  in_y,
  input  logic signed [ptp_pkg::COORD_W-1:0]  in_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ptp_pkg::COORD_W-1:0]  out_x,
  output logic signed [ptp_pkg::COORD_W-1:0]  out_y,
  output logic signed [ptp_pkg::COORD_W-1:0]  out_z,
  output logic                                w_was_zero,
  output logic                                saturated
);
  import ptp_pkg::*;

  localparam int COL_LAT  = 3;
  localparam int DIV_LAT  = DIV_STEPS + 1;
  localparam int WZ_LEN   = DIV_LAT + 2;
  localparam int PIPE_LEN = COL_LAT + WZ_LEN;
  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0]          cfg [0:CFG_NUM-1];
  logic signed [COORD_W-1:0] coef [0:3][0:3];
  logic                      vld [0:PIPE_LEN-1];
  logic                      wz  [0:WZ_LEN-1];
  logic                      adv;

  logic                      col_neg [0:3];
  logic [MAG_W-1:0]          col_mag [0:3];

  logic [MAG_W-1:0]          w_red;
  logic [COORD_W-1:0]        wmag;
  logic                      wzero;

  logic [MAG_W-1:0]          dvd  [0:2];
  logic [COORD_W-1:0]        dvs;
  logic                      sgn  [0:2];

  logic [COORD_W-1:0]        quo  [0:2];
  logic                      ovf  [0:2];
  logic                      qneg [0:2];
  clamp_t                    cl   [0:2];

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[CFG_ROW0_C01] <= ONE;
      cfg[CFG_ROW0_C23] <= '0;
      cfg[CFG_ROW1_C01] <= ONE << COORD_W;
      cfg[CFG_ROW1_C23] <= '0;
      cfg[CFG_ROW2_C01] <= '0;
      cfg[CFG_ROW2_C23] <= ONE;
      cfg[CFG_ROW3_C01] <= '0;
      cfg[CFG_ROW3_C23] <= ONE << COORD_W;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW0_C01: cfg[CFG_ROW0_C01] <= cfg_data;
        CFG_ROW0_C23: cfg[CFG_ROW0_C23] <= cfg_data;
        CFG_ROW1_C01: cfg[CFG_ROW1_C01] <= cfg_data;
        CFG_ROW1_C23: cfg[CFG_ROW1_C23] <= cfg_data;
        CFG_ROW2_C01: cfg[CFG_ROW2_C01] <= cfg_data;
        CFG_ROW2_C23: cfg[CFG_ROW2_C23] <= cfg_data;
        CFG_ROW3_C01: cfg[CFG_ROW3_C01] <= cfg_data;
        CFG_ROW3_C23: cfg[CFG_ROW3_C23] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (c % 2 == 1) begin : g_hi
        assign coef[r][c] = cfg[r*2 + c/2][CFG_W-1:COORD_W];
      end else begin : g_lo
        assign coef[r][c] = cfg[r*2 + c/2][COORD_W-1:0];
      end
    end
  end

  // ---------------- flow control: hold everything while a result waits
  assign adv      = !vld[PIPE_LEN-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LEN; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < PIPE_LEN; k++) vld[k] <= vld[k-1];
    end
  end

  // ---------------- column sums
  for (genvar c = 0; c < 4; c++) begin : g_sum
    ptp_column #(.FRAC_BITS(FRAC_BITS)) u_col (
      .clk (clk),
      .en  (adv),
      .x   (in_x),
      .y   (in_y),
      .z   (in_z),
      .m0  (coef[0][c]),
      .m1  (coef[1][c]),
      .m2  (coef[2][c]),
      .m3  (coef[3][c]),
      .neg (col_neg[c]),
      .mag (col_mag[c])
    );
  end

  // ---------------- w reduction and divisor select
  assign w_red = col_mag[3] >> FRAC_BITS;

  always_comb begin
    if (!col_neg[3] && w_red > MAG_W'(POS_MAX)) begin
      wmag = POS_MAX;
    end else if (col_neg[3] && w_red > MAG_W'(NEG_MAX)) begin
      wmag = NEG_MAX;
    end else begin
      wmag = w_red[COORD_W-1:0];
    end
    wzero = (wmag == '0);
  end

  // zero w divides the shifted sum by one so both cases share the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      dvs   <= wzero ? COORD_W'(1) : wmag;
      wz[0] <= wzero;
      for (int c = 0; c < 3; c++) begin
        dvd[c] <= wzero ? (col_mag[c] >> FRAC_BITS) : col_mag[c];
        sgn[c] <= wzero ? col_neg[c] : (col_neg[c] ^ col_neg[3]);
      end
      for (int k = 1; k < WZ_LEN; k++) wz[k] <= wz[k-1];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    ptp_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (dvd[c]),
      .divisor  (dvs),
      .neg      (sgn[c]),
      .quo      (quo[c]),
      .ovf      (ovf[c]),
      .neg_out  (qneg[c])
    );
    assign cl[c] = ptp_clamp(qneg[c], ovf[c], quo[c]);
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x      <= cl[0].val;
      out_y      <= cl[1].val;
      out_z      <= cl[2].val;
      saturated  <= cl[0].sat | cl[1].sat | cl[2].sat;
      w_was_zero <= wz[WZ_LEN-2];
    end
  end

  assign out_valid = vld[PIPE_LEN-1];

  // ---------------- checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[COL_LAT]) |=> vld[COL_LAT+1])
    else $error("item lost entering the divider");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && vld[COL_LAT]) |=> vld[COL_LAT])
    else $error("stage moved during a stall");

endmodule
